FILE: src/kae_pkg.sv
// shared types, constants and decode function for the keypad autorepeat block
package kae_pkg;

   localparam int ButtonWidth = 6;
   localparam int DelayWidth  = 8;

   localparam logic [DelayWidth-1:0] RESET_INITIAL_DELAY = 8'd30;
   localparam logic [DelayWidth-1:0] RESET_FASTEST_DELAY = 8'd10;
   localparam logic [DelayWidth-1:0] RESET_DELAY_STEP    = 8'd5;
   localparam logic [DelayWidth-1:0] HOLD_MAX            = 8'hFF;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_NEXT      = 3'd1,
      EV_DECREMENT = 3'd2,
      EV_ENTER     = 3'd3,
      EV_INCREMENT = 3'd4,
      EV_ESCAPE    = 3'd5,
      EV_PREVIOUS  = 3'd6
   } nav_event_type;

   typedef enum logic [1:0] {
      REG_INITIAL_DELAY = 2'd0,
      REG_FASTEST_DELAY = 2'd1,
      REG_DELAY_STEP    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DelayWidth-1:0] initial_delay;
      logic [DelayWidth-1:0] fastest_delay;
      logic [DelayWidth-1:0] delay_step;
   } cfg_type;

   typedef struct packed {
      nav_event_type nav_event;
      logic          is_repeat;
   } result_type;

   // one pressed button maps to its event, anything else to none
   function automatic nav_event_type decode_single(input logic [ButtonWidth-1:0] buttons);
      nav_event_type ev;
      ev = EV_NONE;
      unique case (buttons)
         6'h01:   ev = EV_NEXT;
         6'h02:   ev = EV_DECREMENT;
         6'h04:   ev = EV_ENTER;
         6'h08:   ev = EV_INCREMENT;
         6'h10:   ev = EV_ESCAPE;
         6'h20:   ev = EV_PREVIOUS;
         default: ev = EV_NONE;
      endcase
      return ev;
   endfunction

endpackage

FILE: src/kae_csr.sv
// configuration register file for the keypad autorepeat block
module kae_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [kae_pkg::DelayWidth-1:0]    csr_wdata,
   output kae_pkg::cfg_type                  cfg
);

   kae_pkg::cfg_type cfg_ff;
   kae_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (kae_pkg::csr_index_type'(csr_index))
            kae_pkg::REG_INITIAL_DELAY: cfg_in.initial_delay = csr_wdata;
            kae_pkg::REG_FASTEST_DELAY: cfg_in.fastest_delay = csr_wdata;
            kae_pkg::REG_DELAY_STEP:    cfg_in.delay_step    = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_delay <= kae_pkg::RESET_INITIAL_DELAY;
         cfg_ff.fastest_delay <= kae_pkg::RESET_FASTEST_DELAY;
         cfg_ff.delay_step    <= kae_pkg::RESET_DELAY_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: src/kae_core.sv
// debounce, hold counter and accelerating repeat state
module kae_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [kae_pkg::ButtonWidth-1:0]   raw_buttons,
   input  kae_pkg::cfg_type                  cfg,
   output kae_pkg::result_type               result
);

   logic [kae_pkg::ButtonWidth-1:0] last_raw_ff, last_raw_in;
   logic [kae_pkg::ButtonWidth-1:0] held_buttons_ff, held_buttons_in;
   kae_pkg::nav_event_type          held_event_ff, held_event_in;
   logic [kae_pkg::DelayWidth-1:0]  repeat_delay_ff, repeat_delay_in;
   logic [kae_pkg::DelayWidth-1:0]  hold_ticks_ff, hold_ticks_in;

   logic [kae_pkg::ButtonWidth-1:0] qual;
   logic [kae_pkg::DelayWidth-1:0]  hold_inc;
   logic [kae_pkg::DelayWidth-1:0]  room;
   kae_pkg::nav_event_type          new_event;

   always_comb begin
      qual      = (raw_buttons == last_raw_ff) ? raw_buttons : '0;
      hold_inc  = (hold_ticks_ff == kae_pkg::HOLD_MAX) ? hold_ticks_ff
                                                       : hold_ticks_ff + 8'd1;
      room      = repeat_delay_ff - cfg.fastest_delay;
      new_event = kae_pkg::decode_single(qual);

      last_raw_in      = raw_buttons;
      held_buttons_in  = held_buttons_ff;
      held_event_in    = held_event_ff;
      repeat_delay_in  = repeat_delay_ff;
      hold_ticks_in    = hold_ticks_ff;
      result.nav_event = kae_pkg::EV_NONE;
      result.is_repeat = 1'b0;

      if (qual == '0) begin
         // release or bounce: back to the long delay
         repeat_delay_in = cfg.initial_delay;
         held_event_in   = kae_pkg::EV_NONE;
         held_buttons_in = '0;
         hold_ticks_in   = '0;
      end else if (qual != held_buttons_ff) begin
         held_buttons_in  = qual;
         held_event_in    = new_event;
         hold_ticks_in    = '0;
         if (new_event == kae_pkg::EV_NONE) begin
            repeat_delay_in = cfg.initial_delay;
         end
         result.nav_event = new_event;
      end else begin
         hold_ticks_in = hold_inc;
         if (hold_inc >= repeat_delay_ff) begin
            hold_ticks_in    = '0;
            result.nav_event = held_event_ff;
            result.is_repeat = (held_event_ff != kae_pkg::EV_NONE);
            // shrink toward the fastest delay, floored there
            if (repeat_delay_ff > cfg.fastest_delay) begin
               if (cfg.delay_step >= room) begin
                  repeat_delay_in = cfg.fastest_delay;
               end else begin
                  repeat_delay_in = repeat_delay_ff - cfg.delay_step;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff     <= '0;
         held_buttons_ff <= '0;
         held_event_ff   <= kae_pkg::EV_NONE;
         repeat_delay_ff <= kae_pkg::RESET_INITIAL_DELAY;
         hold_ticks_ff   <= '0;
      end else if (advance) begin
         last_raw_ff     <= last_raw_in;
         held_buttons_ff <= held_buttons_in;
         held_event_ff   <= held_event_in;
         repeat_delay_ff <= repeat_delay_in;
         hold_ticks_ff   <= hold_ticks_in;
      end
   end

endmodule

FILE: src/keypad_autorepeat_events_top.sv
// top level of the keypad debounce and accelerating autorepeat block
//
// channel  direction  ports                                    word
// req      in         req_valid req_ready req_raw_buttons      one button sample per tick
// rsp      out        rsp_valid rsp_ready rsp_nav_event/_is_repeat  one event per sample
// csr      in         csr_valid csr_ready csr_index csr_wdata  one register write
//
// each sample word lands in an input register, is processed combinationally and its
// event lands in the result register once that register is free or draining, and
// rsp_valid rises with it; the event then leaves from the result register
// a new sample is taken every cycle while req_ready is high; throughput is one word per cycle
// synchronous active-high reset clears state, delays go back to 30/10/5
// a stalled result holds in the result register while one more sample waits in
// the input register; req_ready drops only when both are full and rsp_ready is low
module keypad_autorepeat_events_top (
   input  logic                            clock,
   input  logic                            reset,
   // sample channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [kae_pkg::ButtonWidth-1:0] req_raw_buttons,
   // event channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_nav_event,
   output logic                            rsp_is_repeat,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [kae_pkg::DelayWidth-1:0]  csr_wdata
);

   // input register
   logic                            in_valid_ff, in_valid_in;
   logic [kae_pkg::ButtonWidth-1:0] in_raw_ff;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   kae_pkg::result_type             rsp_word_ff;

   kae_pkg::cfg_type                cfg;
   kae_pkg::result_type             result;
   logic                            advance;
   logic                            req_take;

   kae_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kae_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .raw_buttons (in_raw_ff),
      .cfg         (cfg),
      .result      (result)
   );

   // the sample moves on whenever the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_raw_ff <= req_raw_buttons;
      end
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_nav_event = rsp_word_ff.nav_event;
   assign rsp_is_repeat = rsp_word_ff.is_repeat;

   // a repeat always carries a real event
   a_repeat_has_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.is_repeat |-> rsp_word_ff.nav_event != kae_pkg::EV_NONE)
      else $error("repeat flagged with no event");

   // back-pressure only when both registers are full and the sink stalls
   a_ready_low_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("sample refused while a register was free");

   // a processed sample always shows up as a result next cycle
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed sample lost");

   // a held result stays put while stalled
   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("stalled result changed");

endmodule
